>>> rtl/core/assert_macros.svh
// assert_macros.svh
// Assertion macros for the particle step RTL; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PKS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define PKS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pks_pkg.sv
// pks_pkg.sv
// Widths, register codes and the sine table entry function of the particle step.
// No dependencies.
package pks_pkg;

  localparam int POS_W       = 24;
  localparam int SPD_W       = 16;
  localparam int ANG_W       = 15;
  localparam int AGE_W       = 16;
  localparam int SINE_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int S_TDATA_W   = 128;
  localparam int M_TDATA_W   = 112;

  localparam int SINE_TABLE_DEPTH_DEF       = 1024;
  localparam int POSITION_FRACTION_BITS_DEF = 8;

  localparam logic [16:0] TURN_Q6    = 17'd23040;
  localparam logic [16:0] QUARTER_Q6 = 17'd5760;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_STEP      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_STEP       = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GROWTH_STEP     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_AMOUNT  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_HEADING = 3'd4;

  // Q1.14 sine of one table entry; frac is the entry's place in the turn, Q30.
  function automatic logic signed [SINE_W-1:0] sine_entry(input logic [63:0] frac);
    logic [1:0]         quad;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] s;
    quad = frac[29:28];
    r = frac & 64'h0FFF_FFFF;
    if (quad[0]) r = 64'h1000_0000 - r;
    x = (r * HALF_PI_Q30) >> 28;
    s = signed'(x);
    t = x;
    for (int k = 1; k <= 6; k++) begin
      t = (((t * x) >> 30) * x) >> 30;
      case (k)
        1: t = t / 64'd6;
        2: t = t / 64'd20;
        3: t = t / 64'd42;
        4: t = t / 64'd72;
        5: t = t / 64'd110;
        default: t = t / 64'd156;
      endcase
      if (k % 2 == 1) s = s - signed'(t);
      else s = s + signed'(t);
    end
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    s = (s + 64'sd32768) >>> 16;
    return quad[1] ? SINE_W'(-s) : SINE_W'(s);
  endfunction

endpackage

>>> rtl/core/pks_sine_rom.sv
// pks_sine_rom.sv
// Sine table ROM with two registered read ports, one full turn in DEPTH entries.
// Depends on pks_pkg.
module pks_sine_rom
  import pks_pkg::*;
#(
  parameter int DEPTH = SINE_TABLE_DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [IDX_W-1:0]         addr_a,
  input  logic [IDX_W-1:0]         addr_b,
  output logic signed [SINE_W-1:0] data_a,
  output logic signed [SINE_W-1:0] data_b
);

  logic signed [SINE_W-1:0] rom [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    localparam logic [63:0] FRAC = (64'(i) << 30) / DEPTH;
    assign rom[i] = sine_entry(FRAC);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_a <= rom[addr_a];
      data_b <= rom[addr_b];
    end
  end

endmodule

>>> rtl/core/particle_kinematics_step.sv
// particle_kinematics_step.sv: one tick of one particle, depends on pks_pkg and pks_sine_rom.
// A seven-stage pipeline takes one particle word per cycle unless the output stalls. Its
// stages: age and increments, heading wrap, table index multiply, sine ROM read,
// speed and gravity products, rounding to position units, then the saturating position add
// into the output register. Any stage that holds no word fills while later ones stall, so
// a stall at the output loses and repeats nothing. Write the configuration registers only
// while the pipeline is empty; gravity indexes follow a write via grav_ang then grav_idx.
`include "assert_macros.svh"
module particle_kinematics_step
  import pks_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH       = SINE_TABLE_DEPTH_DEF,
  parameter int POSITION_FRACTION_BITS = POSITION_FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // pos_x, pos_y, speed_in, heading_in, size_in, age_in, lifetime, one zero bit
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // kind_live
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // new_x, new_y, new_speed, new_heading, new_size, new_age, one zero bit
  output logic [M_TDATA_W-1:0]   m_tdata,
  // alive
  output logic                   m_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int NSTAGE = 7;
  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam logic [63:0] IDX_MULT64 =
    ((64'(SINE_TABLE_DEPTH) << 30) + 64'd23039) / 64'd23040;
  localparam logic [29:0] IDX_MULT = IDX_MULT64[29:0];
  localparam int RND_SH = 22 - POSITION_FRACTION_BITS;
  localparam int DSP_W  = 32 - RND_SH;
  localparam int SUM_W  = ((DSP_W > POS_W) ? DSP_W : POS_W) + 2;
  localparam logic [31:0] RND_HALF = 32'd1 << (RND_SH - 1);

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [SPD_W-1:0] spd;
    logic [ANG_W-1:0]        head;
    logic signed [SPD_W-1:0] size;
    logic [AGE_W-1:0]        age;
    logic                    alive;
  } item_t;

  function automatic logic signed [SPD_W-1:0] sat_spd(input logic signed [SPD_W:0] v);
    if (v[SPD_W] != v[SPD_W-1]) begin
      return v[SPD_W] ? {1'b1, {(SPD_W-1){1'b0}}} : {1'b0, {(SPD_W-1){1'b1}}};
    end
    return v[SPD_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-POS_W:0] hi_bits;
    hi_bits = v[SUM_W-1:POS_W-1];
    if (hi_bits == '0 || hi_bits == '1) return v[POS_W-1:0];
    return v[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
  endfunction

  // Reduce an angle below six turns into one turn.
  function automatic logic [ANG_W-1:0] wrap_turn(input logic [16:0] a);
    logic [16:0] r;
    if (a >= 17'd115200)     r = a - 17'd115200;
    else if (a >= 17'd92160) r = a - 17'd92160;
    else if (a >= 17'd69120) r = a - 17'd69120;
    else if (a >= 17'd46080) r = a - 17'd46080;
    else if (a >= TURN_Q6)   r = a - TURN_Q6;
    else                     r = a;
    return r[ANG_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] table_index(input logic [ANG_W-1:0] a);
    logic [44:0] prod;
    prod = 45'(a) * 45'(IDX_MULT);
    return prod[30 +: IDX_W];
  endfunction

  function automatic logic signed [DSP_W-1:0] to_pos(input logic signed [31:0] p);
    logic [31:0] mag;
    logic [31:0] rm;
    mag = p[31] ? 32'(-p) : 32'(p);
    rm = (mag + RND_HALF) >> RND_SH;
    return p[31] ? -DSP_W'(rm) : DSP_W'(rm);
  endfunction

  // Configuration registers
  logic signed [SPD_W-1:0] speed_step;
  logic signed [SPD_W-1:0] turn_step;
  logic signed [SPD_W-1:0] growth_step;
  logic signed [SPD_W-1:0] gravity_amount;
  logic [ANG_W-1:0]        gravity_heading;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_step      <= '0;
      turn_step       <= '0;
      growth_step     <= '0;
      gravity_amount  <= '0;
      gravity_heading <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SPEED_STEP:      speed_step      <= cfg_data;
        REG_TURN_STEP:       turn_step       <= cfg_data;
        REG_GROWTH_STEP:     growth_step     <= cfg_data;
        REG_GRAVITY_AMOUNT:  gravity_amount  <= cfg_data;
        REG_GRAVITY_HEADING: gravity_heading <= cfg_data[ANG_W-1:0];
        default: ;
      endcase
    end
  end

  // Gravity table indexes, refreshed every cycle from the registers
  logic [ANG_W-1:0] grav_ang_s;
  logic [ANG_W-1:0] grav_ang_c;
  logic [IDX_W-1:0] grav_idx_s;
  logic [IDX_W-1:0] grav_idx_c;

  always_ff @(posedge clk) begin
    grav_ang_s <= wrap_turn(17'(gravity_heading));
    grav_ang_c <= wrap_turn(17'(gravity_heading) + QUARTER_Q6);
    grav_idx_s <= table_index(grav_ang_s);
    grav_idx_c <= table_index(grav_ang_c);
  end

  // Stage enables and valid bits
  logic [NSTAGE:1] vld;
  logic [NSTAGE:1] en;

  always_comb begin
    en[NSTAGE] = !vld[NSTAGE] || m_tready;
    for (int k = NSTAGE - 1; k >= 1; k--) en[k] = !vld[k] || en[k+1];
  end

  assign s_tready = en[1];
  assign m_tvalid = vld[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) vld[1] <= s_tvalid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Stage 1: age, life check, speed and size increments, raw heading sum
  logic signed [POS_W-1:0] in_x;
  logic signed [POS_W-1:0] in_y;
  logic signed [SPD_W-1:0] in_spd;
  logic [ANG_W-1:0]        in_head;
  logic signed [SPD_W-1:0] in_size;
  logic [AGE_W-1:0]        in_age;
  logic [AGE_W-1:0]        in_life;
  logic [AGE_W-1:0]        age_next;
  logic signed [17:0]      hsum_next;

  assign in_x    = s_tdata[23:0];
  assign in_y    = s_tdata[47:24];
  assign in_spd  = s_tdata[63:48];
  assign in_head = s_tdata[78:64];
  assign in_size = s_tdata[94:79];
  assign in_age  = s_tdata[110:95];
  assign in_life = s_tdata[126:111];

  assign age_next  = (in_age == '1) ? in_age : in_age + 16'd1;
  assign hsum_next = signed'({3'b000, in_head}) + {{2{turn_step[SPD_W-1]}}, turn_step};

  item_t              item1;
  logic signed [17:0] hsum1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      item1.x     <= in_x;
      item1.y     <= in_y;
      item1.spd   <= sat_spd({in_spd[SPD_W-1], in_spd} + {speed_step[SPD_W-1], speed_step});
      item1.head  <= in_head;
      item1.size  <= sat_spd({in_size[SPD_W-1], in_size}
                             + {growth_step[SPD_W-1], growth_step});
      item1.age   <= age_next;
      item1.alive <= s_tuser && (age_next < in_life);
      hsum1       <= hsum_next;
    end
  end

  // Stage 2: wrap heading and its quarter-turn offset
  logic [16:0]      head_pos;
  item_t            item2_next;
  item_t            item2;
  logic [ANG_W-1:0] cos_ang2;

  assign head_pos = 17'(hsum1 + 18'sd46080);

  always_comb begin
    item2_next      = item1;
    item2_next.head = wrap_turn(head_pos);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      item2    <= item2_next;
      cos_ang2 <= wrap_turn(head_pos + QUARTER_Q6);
    end
  end

  // Stage 3: table indexes
  item_t            item3;
  logic [IDX_W-1:0] sin_idx3;
  logic [IDX_W-1:0] cos_idx3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      item3    <= item2;
      sin_idx3 <= table_index(item2.head);
      cos_idx3 <= table_index(cos_ang2);
    end
  end

  // Stage 4: sine ROM reads
  item_t                    item4;
  logic signed [SINE_W-1:0] sin4;
  logic signed [SINE_W-1:0] cos4;
  logic signed [SINE_W-1:0] gsin4;
  logic signed [SINE_W-1:0] gcos4;

  pks_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_head_rom (
    .clk    (clk),
    .en     (en[4]),
    .addr_a (sin_idx3),
    .addr_b (cos_idx3),
    .data_a (sin4),
    .data_b (cos4)
  );

  pks_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_grav_rom (
    .clk    (clk),
    .en     (en[4]),
    .addr_a (grav_idx_s),
    .addr_b (grav_idx_c),
    .data_a (gsin4),
    .data_b (gcos4)
  );

  always_ff @(posedge clk) begin
    if (en[4]) item4 <= item3;
  end

  // Stage 5: displacement products, 22 fraction bits
  item_t              item5;
  logic signed [31:0] prod_xc5;
  logic signed [31:0] prod_yc5;
  logic signed [31:0] prod_xg5;
  logic signed [31:0] prod_yg5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      item5    <= item4;
      prod_xc5 <= 32'(cos4) * 32'(item4.spd);
      prod_yc5 <= 32'(sin4) * 32'(item4.spd);
      prod_xg5 <= 32'(gcos4) * 32'(gravity_amount);
      prod_yg5 <= 32'(gsin4) * 32'(gravity_amount);
    end
  end

  // Stage 6: round to position units
  item_t                   item6;
  logic signed [DSP_W-1:0] dxc6;
  logic signed [DSP_W-1:0] dyc6;
  logic signed [DSP_W-1:0] dxg6;
  logic signed [DSP_W-1:0] dyg6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      item6 <= item5;
      dxc6  <= to_pos(prod_xc5);
      dyc6  <= to_pos(prod_yc5);
      dxg6  <= to_pos(prod_xg5);
      dyg6  <= to_pos(prod_yg5);
    end
  end

  // Stage 7: position add, saturate, clear a dead word
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic signed [SPD_W-1:0] out_spd;
  logic [ANG_W-1:0]        out_head;
  logic signed [SPD_W-1:0] out_size;
  logic [AGE_W-1:0]        out_age;
  logic                    out_alive;

  assign sum_x = SUM_W'(item6.x) + SUM_W'(dxc6) + SUM_W'(dxg6);
  assign sum_y = SUM_W'(item6.y) - SUM_W'(dyc6) - SUM_W'(dyg6);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      out_alive <= item6.alive;
      if (item6.alive) begin
        out_x    <= sat_pos(sum_x);
        out_y    <= sat_pos(sum_y);
        out_spd  <= item6.spd;
        out_head <= item6.head;
        out_size <= item6.size;
        out_age  <= item6.age;
      end else begin
        out_x    <= '0;
        out_y    <= '0;
        out_spd  <= '0;
        out_head <= '0;
        out_size <= '0;
        out_age  <= '0;
      end
    end
  end

  assign m_tdata = {1'b0, out_age, out_size, out_head, out_spd, out_y, out_x};
  assign m_tuser = out_alive;

  `PKS_ASSERT_IMPLY(a_dead_clear, clk, rst, m_tvalid && !m_tuser, m_tdata == '0, "dead word has nonzero fields")
  `PKS_ASSERT_IMPLY(a_live_range, clk, rst, m_tvalid && m_tuser, (m_tdata[78:64] < TURN_Q6) && (m_tdata[110:95] != 16'd0), "live word heading or age out of range")
  `PKS_ASSERT_IMPLY(a_empty_ready, clk, rst, !m_tvalid, s_tready, "input stalled with empty output")
  `PKS_ASSERT_NEXT(a_accept_enter, clk, rst, s_tvalid && s_tready, vld[1], "accepted word missing from first stage")

endmodule

>>> sim/particle_kinematics_step_checker.sv
`timescale 1ns / 100ps
// particle_kinematics_step_checker.sv: predicts the result word of every accepted particle
// word from its own copy of the step registers and sine table, and compares it on output.
// Depends on pks_pkg.
module particle_kinematics_step_checker
  import pks_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [S_TDATA_W-1:0]   s_tdata,
  input  logic                   s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [M_TDATA_W-1:0]   m_tdata,
  input  logic                   m_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     in_flight
);
  localparam int     DEPTH     = SINE_TABLE_DEPTH_DEF;
  localparam int     FRAC_BITS = POSITION_FRACTION_BITS_DEF;
  localparam longint TURN      = longint'(TURN_Q6);
  localparam longint QUARTER   = longint'(QUARTER_Q6);

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [SPD_W-1:0] speed;
    logic [ANG_W-1:0]        heading;
    logic signed [SPD_W-1:0] size;
    logic [AGE_W-1:0]        age;
    logic                    alive;
  } particle_t;

  logic signed [SINE_W-1:0] sine_rom [DEPTH];
  longint    speed_inc, turn_inc, growth_inc, grav_amount, grav_heading;
  particle_t pending_results [$];
  int        errors = 0;

  function automatic logic signed [SINE_W-1:0] rom_entry(int unsigned i);
    longint unsigned f, r, x, term;
    longint          acc;
    int unsigned     quad;
    int              k;
    f = (64'(i) << 30) / DEPTH;
    quad = int'((f >> 28) & 64'd3);
    r = f & 64'h0FFF_FFFF;
    if (quad[0]) r = 64'h1000_0000 - r;
    x = (r * HALF_PI_Q30) >> 28;
    acc = longint'(x);
    term = x;
    for (k = 1; k <= 6; k++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    if (acc > 64'sd1073741824) acc = 64'sd1073741824;
    acc = (acc + 32768) / 65536;
    return (quad >= 2) ? SINE_W'(-acc) : SINE_W'(acc);
  endfunction

  initial begin
    for (int i = 0; i < DEPTH; i++) sine_rom[i] = rom_entry(i);
  end

  function automatic longint wrap_turn(longint a);
    longint r;
    r = a % TURN;
    return (r < 0) ? r + TURN : r;
  endfunction

  function automatic longint sine_at(longint angle);
    longint idx;
    idx = wrap_turn(angle) * DEPTH / TURN;
    if (idx >= DEPTH) idx = DEPTH - 1;
    return longint'(sine_rom[idx]);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // round half away from zero from 22 fraction bits down to position units
  function automatic longint to_position(longint p);
    int     sh;
    longint half;
    sh = 22 - FRAC_BITS;
    half = 64'sd1 <<< (sh - 1);
    if (p < 0) return -((-p + half) >>> sh);
    return (p + half) >>> sh;
  endfunction

  function automatic particle_t advance_particle(logic [S_TDATA_W-1:0] w, logic live);
    longint    px, py, spd, hd, sz, dx, dy;
    int        age, life, nage;
    particle_t r;
    r = '0;
    px = longint'(signed'(w[23:0]));
    py = longint'(signed'(w[47:24]));
    spd = longint'(signed'(w[63:48]));
    hd = longint'(w[78:64]);
    sz = longint'(signed'(w[94:79]));
    age = int'(w[110:95]);
    life = int'(w[126:111]);
    nage = (age < 65535) ? age + 1 : 65535;
    if (!live || nage >= life) return r;
    spd = clamp(spd + speed_inc, -32768, 32767);
    hd = wrap_turn(hd + turn_inc);
    sz = clamp(sz + growth_inc, -32768, 32767);
    dx = to_position(sine_at(hd + QUARTER) * spd);
    dy = to_position(sine_at(hd) * spd);
    if (grav_amount != 0) begin
      dx += to_position(sine_at(grav_heading + QUARTER) * grav_amount);
      dy += to_position(sine_at(grav_heading) * grav_amount);
    end
    r.x = POS_W'(clamp(px + dx, -8388608, 8388607));
    r.y = POS_W'(clamp(py - dy, -8388608, 8388607));
    r.speed = SPD_W'(spd);
    r.heading = ANG_W'(hd);
    r.size = SPD_W'(sz);
    r.age = AGE_W'(nage);
    r.alive = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    particle_t got, want;
    if (rst) begin
      speed_inc = 0;
      turn_inc = 0;
      growth_inc = 0;
      grav_amount = 0;
      grav_heading = 0;
      pending_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.x = m_tdata[23:0];
        got.y = m_tdata[47:24];
        got.speed = m_tdata[63:48];
        got.heading = m_tdata[78:64];
        got.size = m_tdata[94:79];
        got.age = m_tdata[110:95];
        got.alive = m_tuser;
        if (pending_results.size() == 0) begin
          if (errors < 10)
            $display("%0t: result word with none outstanding: x=%0d y=%0d alive=%0b",
                     $time, got.x, got.y, got.alive);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            if (errors < 10) begin
              $display("%0t: mismatch", $time);
              $display("  expected x=%0d y=%0d speed=%0d heading=%0d size=%0d age=%0d alive=%0b",
                       want.x, want.y, want.speed, want.heading, want.size, want.age,
                       want.alive);
              $display("  actual   x=%0d y=%0d speed=%0d heading=%0d size=%0d age=%0d alive=%0b",
                       got.x, got.y, got.speed, got.heading, got.size, got.age, got.alive);
            end
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) pending_results.push_back(advance_particle(s_tdata, s_tuser));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPEED_STEP:      speed_inc = longint'(signed'(cfg_data));
          REG_TURN_STEP:       turn_inc = longint'(signed'(cfg_data));
          REG_GROWTH_STEP:     growth_inc = longint'(signed'(cfg_data));
          REG_GRAVITY_AMOUNT:  grav_amount = longint'(signed'(cfg_data));
          REG_GRAVITY_HEADING: grav_heading = longint'(cfg_data[ANG_W-1:0]);
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    in_flight <= pending_results.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// tb.sv: top of the particle step testbench. Makes particle words in random bursts, stalls
// the result channel, writes the step registers between phases and gives the verdict.
// Depends on pks_pkg, particle_kinematics_step and particle_kinematics_step_checker.
module tb;
  import pks_pkg::*;

  localparam int LIMIT       = 400000;
  localparam int PHASE_ITEMS = 160;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     fail_count;
  int                     in_flight;
  int                     cycles = 0;
  int                     burst_left = 0;
  int                     stall_left = 0;
  int                     stall_mode = 0;

  always #2 clk = ~clk;

  particle_kinematics_step i_dut (.*);

  particle_kinematics_step_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("particle_kinematics_step test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= cycles[3];
    endcase
  end

  task automatic drain();
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] spd, turn, grow, amount,
                               input logic [14:0] heading);
    drain();
    write_reg(REG_SPEED_STEP, spd);
    write_reg(REG_TURN_STEP, turn);
    write_reg(REG_GROWTH_STEP, grow);
    write_reg(REG_GRAVITY_AMOUNT, amount);
    write_reg(REG_GRAVITY_HEADING, {1'($urandom), heading});
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++)
      write_reg(CFG_INDEX_W'(i), 16'($urandom));
    cfg_valid <= 1'b0;
    // let the gravity table index settle
    repeat (4) @(posedge clk);
  endtask

  task automatic send_particle(input logic [23:0] x, y, input logic [15:0] spd,
                               input logic [14:0] heading, input logic [15:0] sz, age, life,
                               input logic live, input bit last);
    s_tdata <= {1'b0, life, age, sz, heading, spd, y, x};
    s_tuser <= live;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (last || burst_left == 0) begin
      s_tvalid <= 1'b0;
      if (!last) repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                : $urandom_range(0, 16);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic [15:0] pick_word16();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [23:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return 24'h7FFFFF - 24'($urandom_range(0, 4095));
      1: return 24'h800000 + 24'($urandom_range(0, 4095));
      2: return 24'($urandom_range(0, 65535) - 32768);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_random(input bit last);
    logic [15:0] age, life;
    logic [14:0] heading;
    if ($urandom_range(0, 9) < 8) begin
      life = 16'($urandom_range(2, 65535));
      age = 16'($urandom_range(0, life - 2));
    end else begin
      life = 16'($urandom);
      age = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    end
    heading = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'($urandom_range(0, 23039));
    send_particle(pick_pos(), pick_pos(), pick_word16(), heading, pick_word16(), age, life,
                  $urandom_range(0, 19) != 0, last);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    load_settings(16'd300, 16'd23039, 16'h8000, 16'h7FFF, 15'h7FFF);
    send_particle(24'd0, 24'd0, 16'd256, 15'd0, 16'd256, 16'd0, 16'd100, 1'b0, 1'b0);
    send_particle(24'd0, 24'd0, 16'd256, 15'd0, 16'd256, 16'd0, 16'd0, 1'b1, 1'b0);
    send_particle(24'd0, 24'd0, 16'd256, 15'd0, 16'd256, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    send_particle(24'd0, 24'd0, 16'd256, 15'd0, 16'd256, 16'hFFFE, 16'hFFFF, 1'b1, 1'b0);
    send_particle(24'd0, 24'd0, 16'd0, 15'd0, 16'd0, 16'd0, 16'd2, 1'b1, 1'b0);
    send_particle(24'h7FFFFF, 24'h800000, 16'h7FFF, 15'd0, 16'h7FFF, 16'd0, 16'hFFFF,
                  1'b1, 1'b0);
    send_particle(24'h800000, 24'h7FFFFF, 16'h8000, 15'd11520, 16'h8000, 16'd10, 16'd20,
                  1'b1, 1'b0);
    send_particle(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 15'd5760, 16'd0, 16'd5, 16'd9,
                  1'b1, 1'b0);
    send_particle(24'h800000, 24'h800000, 16'h8000, 15'd17280, 16'hFFFF, 16'd1, 16'd3,
                  1'b1, 1'b0);
    send_particle(24'd1000, 24'd2000, 16'd512, 15'd23039, 16'd256, 16'd0, 16'd50, 1'b1, 1'b0);
    send_particle(24'd1000, 24'd2000, 16'd512, 15'd23040, 16'd256, 16'd0, 16'd50, 1'b1, 1'b0);
    send_particle(24'd1000, 24'd2000, 16'd512, 15'h7FFF, 16'd256, 16'd0, 16'd50, 1'b1, 1'b0);
    send_particle(24'h01E240, 24'hF60B0F, 16'h1234, 15'd4321, 16'h0F0F, 16'd77, 16'd999,
                  1'b1, 1'b0);
    send_particle(24'hFFFFFF, 24'd1, 16'hFFFF, 15'd1, 16'hAAAA, 16'h5555, 16'hAAAA,
                  1'b1, 1'b0);
    send_particle(24'h555555, 24'hAAAAAA, 16'd1, 15'h5555, 16'h5555, 16'd1000, 16'hFFFF,
                  1'b1, 1'b1);

    for (int p = 1; p <= 8; p++) begin
      case (p)
        1: load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h0000);
        2: load_settings(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 15'h7FFF);
        3: load_settings(16'h8000, 16'h8000, 16'h8000, 16'h8000, 15'h0000);
        default: load_settings(pick_word16(),
                               ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                 : 16'($urandom_range(0, 46078) - 23039),
                               pick_word16(),
                               ($urandom_range(0, 3) == 0) ? 16'h0000 : pick_word16(),
                               15'($urandom));
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) send_random(n == PHASE_ITEMS - 1);
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("particle_kinematics_step test passed");
    end else begin
      $display("particle_kinematics_step test failed");
    end
    $finish;
  end

endmodule
